// ===== sv/jpeg_exif_rating_extractor_top_macros.svh =====
// Assertion helpers for the rating extractor.
`ifndef JPEG_EXIF_RATING_EXTRACTOR_TOP_MACROS_SVH
`define JPEG_EXIF_RATING_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define JER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jer_pkg.sv =====
`default_nettype none

package jer_pkg;

  // Marker and signature constants, and the reset value of the tag
  localparam logic [7:0]  MarkFf    = 8'hFF;
  localparam logic [7:0]  MarkSoi   = 8'hD8;
  localparam logic [7:0]  MarkApp1  = 8'hE1;
  localparam logic [7:0]  MarkSos   = 8'hDA;
  localparam logic [7:0]  MarkEoi   = 8'hD9;
  localparam logic [7:0]  MarkApp0  = 8'hE0;
  localparam logic [7:0]  MarkApp15 = 8'hEF;
  localparam logic [7:0]  TiffLeId  = 8'h49;
  localparam logic [31:0] ExifWord  = 32'h45786966;
  localparam logic [15:0] TagReset  = 16'h4746;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rating;
    logic        found;
  } out_item_t;

  // Result handed from the parser to the output buffer
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/jer_parser.sv =====
`default_nettype none

module jer_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire jer_pkg::in_item_t item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [15:0]      cfg_data_i,
  output jer_pkg::res_t         res_o
);

  typedef enum logic [3:0] {
    PH_START0, PH_START1, PH_SCAN, PH_MARKER, PH_APPLEN, PH_APP1LEN, PH_APP1HDR,
    PH_SKIPSEG, PH_TIFFHDR, PH_SKIPIFD, PH_COUNT, PH_ENTRY, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] skip_q, skip_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] asm_q, asm_d;
  logic        le_q, le_d;
  logic [15:0] left_q, left_d;
  logic        match_q, match_d;
  logic [15:0] tag_q;

  logic [7:0]  b;
  logic [15:0] len_w, len_m2;
  logic [31:0] skip_dec, asm_tiff, ifd_off;
  logic [15:0] pair_w, left_dec;

  function automatic logic [15:0] pair16(input logic le, input logic [7:0] a,
                                         input logic [7:0] c);
    return le ? {c, a} : {a, c};
  endfunction

  // Shared datapath terms
  assign b        = item_i.data_byte;
  assign len_w    = {asm_q[7:0], b};
  assign len_m2   = (len_w >= 16'd2) ? (len_w - 16'd2) : 16'd0;
  assign skip_dec = skip_q - 32'd1;
  assign asm_tiff = (idx_q >= 4'd4) ? (le_q ? {b, asm_q[31:8]} : {asm_q[23:0], b}) : asm_q;
  assign ifd_off  = (asm_tiff >= 32'd8) ? (asm_tiff - 32'd8) : 32'd0;
  assign pair_w   = pair16(le_q, asm_q[7:0], b);
  assign left_dec = left_q - 16'd1;

  // Next state for one accepted byte
  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    idx_d   = idx_q;
    asm_d   = asm_q;
    le_d    = le_q;
    left_d  = left_q;
    match_d = match_q;
    res_o   = '0;
    if (accept_i) begin
      case (phase_q)
        PH_START0: begin
          if (b == jer_pkg::MarkFf) phase_d = PH_START1;
          else res_o.valid = 1'b1;
        end
        PH_START1: begin
          if (b == jer_pkg::MarkSoi) phase_d = PH_SCAN;
          else res_o.valid = 1'b1;
        end
        PH_SCAN: begin
          if (b == jer_pkg::MarkFf) phase_d = PH_MARKER;
        end
        PH_MARKER: begin
          idx_d = '0;
          if (b == jer_pkg::MarkSos || b == jer_pkg::MarkEoi) res_o.valid = 1'b1;
          else if (b == jer_pkg::MarkApp1) phase_d = PH_APP1LEN;
          else if (b >= jer_pkg::MarkApp0 && b <= jer_pkg::MarkApp15) phase_d = PH_APPLEN;
          else phase_d = PH_SCAN;
        end
        PH_APPLEN, PH_APP1LEN: begin
          if (idx_q == 4'd0) begin
            asm_d = {24'd0, b};
            idx_d = 4'd1;
          end else begin
            idx_d  = '0;
            skip_d = {16'd0, len_m2};
            if (phase_q == PH_APPLEN) begin
              phase_d = (len_m2 != 16'd0) ? PH_SKIPSEG : PH_SCAN;
            end else begin
              asm_d   = '0;
              phase_d = PH_APP1HDR;
            end
          end
        end
        PH_APP1HDR: begin
          if (idx_q < 4'd4) asm_d = {asm_q[23:0], b};
          if (skip_q != 32'd0) skip_d = skip_dec;
          if (idx_q < 4'd5) begin
            idx_d = idx_q + 4'd1;
          end else begin
            idx_d = '0;
            if (asm_q == jer_pkg::ExifWord) phase_d = PH_TIFFHDR;
            else phase_d = (skip_d != 32'd0) ? PH_SKIPSEG : PH_SCAN;
          end
        end
        PH_SKIPSEG, PH_SKIPIFD: begin
          skip_d = skip_dec;
          if (skip_dec == 32'd0) phase_d = (phase_q == PH_SKIPSEG) ? PH_SCAN : PH_COUNT;
        end
        PH_TIFFHDR: begin
          if (idx_q == 4'd0) le_d = (b == jer_pkg::TiffLeId);
          asm_d = asm_tiff;
          if (idx_q < 4'd7) begin
            idx_d = idx_q + 4'd1;
          end else begin
            idx_d   = '0;
            skip_d  = ifd_off;
            phase_d = (ifd_off != 32'd0) ? PH_SKIPIFD : PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (idx_q == 4'd0) begin
            asm_d = {24'd0, b};
            idx_d = 4'd1;
          end else begin
            idx_d  = '0;
            left_d = pair_w;
            if (pair_w == 16'd0) res_o.valid = 1'b1;
            else phase_d = PH_ENTRY;
          end
        end
        PH_ENTRY: begin
          if (idx_q == 4'd9 && match_q) begin
            res_o.valid       = 1'b1;
            res_o.item.rating = pair_w;
            res_o.item.found  = 1'b1;
          end else begin
            if (idx_q == 4'd0 || idx_q == 4'd8) asm_d = {24'd0, b};
            else if (idx_q == 4'd1) match_d = (pair_w == tag_q);
            if (idx_q < 4'd11) begin
              idx_d = idx_q + 4'd1;
            end else begin
              idx_d  = '0;
              left_d = left_dec;
              if (left_dec == 16'd0) res_o.valid = 1'b1;
            end
          end
        end
        default: ;
      endcase
      // A result ends the file's parse
      if (res_o.valid) phase_d = PH_DONE;
      // End of file: report a miss if nothing was given, then restart
      if (item_i.last_byte) begin
        if (phase_q != PH_DONE && !res_o.valid) res_o.valid = 1'b1;
        phase_d = PH_START0;
        skip_d  = '0;
        idx_d   = '0;
        asm_d   = '0;
        le_d    = 1'b0;
        left_d  = '0;
        match_d = 1'b0;
      end
    end
  end

  // Parser state and tag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START0;
      skip_q  <= '0;
      idx_q   <= '0;
      asm_q   <= '0;
      le_q    <= 1'b0;
      left_q  <= '0;
      match_q <= 1'b0;
      tag_q   <= jer_pkg::TagReset;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      idx_q   <= idx_d;
      asm_q   <= asm_d;
      le_q    <= le_d;
      left_q  <= left_d;
      match_q <= match_d;
      if (cfg_we_i) tag_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/jer_out_buf.sv =====
`default_nettype none

module jer_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire jer_pkg::res_t res_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output jer_pkg::out_item_t out_item_o,
  output logic               full_o
);

  logic               out_valid_q, skid_valid_q;
  jer_pkg::out_item_t out_item_q, skid_item_q;
  logic               move;

  assign move = !out_valid_q || !out_stall_i;

  // Valid flags: skid takes a result while the output is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (move) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_i.valid;
      end
    end else if (res_i.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (move) begin
      if (skid_valid_q) out_item_q <= skid_item_q;
      else if (res_i.valid) out_item_q <= res_i.item;
    end else if (res_i.valid) begin
      skid_item_q <= res_i.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign full_o      = skid_valid_q;

endmodule

`default_nettype wire

// ===== sv/jpeg_exif_rating_extractor_top.sv =====
// A result is registered into the output register, or into the skid while the output is held, from its byte.
// Throughput: one byte per cycle while in_stall_o is low; the parser updates its state once per accepted byte.
// A two-entry output register and skid keep input flowing while a result waits.
// Reset (rst_ni low, asynchronous): parser back to start marker, tag set to 0x4746,
// output and skid emptied; no clearing pass is needed.
`default_nettype none

`include "jpeg_exif_rating_extractor_top_macros.svh"

module jpeg_exif_rating_extractor_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire jer_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output jer_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i
);

  logic          accept;
  jer_pkg::res_t res;

  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Byte parser
  jer_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  // Result register and skid
  jer_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .full_o      (in_stall_o)
  );

  // Checks
  `JER_ASSERT_NOW(a_res_needs_accept, res.valid, accept, "result without accepted item")
  `JER_ASSERT_NOW(a_stall_has_output, in_stall_o, out_valid_o, "skid full with empty output")
  `JER_ASSERT_NOW(a_miss_is_zero, out_valid_o && !out_item_o.found,
                  out_item_o.rating == 16'd0, "miss with nonzero rating")
  `JER_ASSERT_NEXT(a_skid_fill, out_valid_o && out_stall_i && res.valid, in_stall_o,
                   "held result lost")

endmodule

`default_nettype wire
